>>> sv/fdaf_pkg.sv
// ----------------------------------------------------------------------------
// fdaf_pkg
// Shared types and constants for the frame destination address filter:
// command and mode codes, result kinds, register indexes, table shape and
// the compare flags that travel between pipeline stages.
// ----------------------------------------------------------------------------
package fdaf_pkg;

    // secondary address table shape
    localparam int TABLE_DEPTH = 7;
    localparam int ENTRY_W     = 64;
    localparam int HALF_W      = 32;
    localparam int SHORT_W     = 16;
    localparam int IDX_W       = 3;

    // broadcast patterns
    localparam logic [SHORT_W-1:0] SHORT_BCAST     = 16'hffff;
    localparam logic [SHORT_W-1:0] SHORT_BCAST_ALT = 16'hfffe;
    localparam logic [HALF_W-1:0]  EXT_BCAST_LO    = 32'hffffffff;
    localparam logic [HALF_W-1:0]  EXT_BCAST_LO_ALT = 32'hfffffffe;
    localparam logic [HALF_W-1:0]  EXT_BCAST_HI    = 32'hffffffff;

    // input word command
    typedef enum logic {
        CMD_FILTER = 1'b0,
        CMD_WRITE  = 1'b1
    } cmd_e;

    // destination addressing modes
    localparam logic [1:0] MODE_SHORT    = 2'd2;
    localparam logic [1:0] MODE_EXTENDED = 2'd3;

    // result classification
    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_UNICAST   = 2'd1,
        KIND_BROADCAST = 2'd2
    } kind_e;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PAN_ID        = 3'd0,
        CFG_OWN_ADDR_LOW  = 3'd1,
        CFG_OWN_ADDR_HIGH = 3'd2,
        CFG_EXTRA_ENABLE  = 3'd3,
        CFG_EXTRA_COUNT   = 3'd4
    } cfg_index_e;

    typedef logic [TABLE_DEPTH-1:0][ENTRY_W-1:0] table_t;

    // configuration register file
    typedef struct packed {
        logic [15:0]       pan_id;
        logic [HALF_W-1:0] own_addr_low;
        logic [HALF_W-1:0] own_addr_high;
        logic              extra_enable;
        logic [2:0]        extra_count;
    } cfg_t;

    // input word held in the first stage
    typedef struct packed {
        cmd_e              cmd;
        logic [15:0]       dest_pan;
        logic [1:0]        dest_mode;
        logic [HALF_W-1:0] dest_low;
        logic [HALF_W-1:0] dest_high;
        logic [IDX_W-1:0]  entry_index;
        logic [HALF_W-1:0] entry_low;
        logic [HALF_W-1:0] entry_high;
    } item_t;

    // compare flags handed from the compare stage to the resolve stage
    typedef struct packed {
        logic                   pan_ok;
        logic                   addr_mode;
        logic                   bcast;
        logic                   own_hit;
        logic [TABLE_DEPTH-1:0] lane_hit;
    } cmp_t;

endpackage

>>> sv/frame_dest_address_filter_top.sv
// ----------------------------------------------------------------------------
// frame_dest_address_filter_top
// Classifies received frame destinations as no match, unicast or broadcast
// and loads the secondary address table.
//
// Usage:
//   s_* channel: one word per valid/ready handshake. s_cmd selects a filter
//   word (destination PAN, mode, address) or a table write word (slot index
//   and 64-bit address). Write words produce no result.
//   m_* channel: one m_match_kind word per filter word, in order.
//   cfg_* channel: register writes by index, always ready; write only while
//   the block is idle.
//   Path: a filter word passes the input register, the compare stage and
//   the resolve/output register before it shows on m_valid.
//   Throughput: one word per cycle while s_ready is high; all table slots are compared in
//   parallel lanes inside the single compare stage.
//   Reset (aresetn low, synchronous): pipeline emptied, configuration
//   registers and the table cleared to zero.
//   Stall: each stage holds while the one after it is full and stalled, so
//   s_ready drops only once all three stages hold words and m_ready is low.
// ----------------------------------------------------------------------------
module frame_dest_address_filter_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [15:0] s_dest_pan,
    input  logic [1:0]  s_dest_mode,
    input  logic [31:0] s_dest_low,
    input  logic [31:0] s_dest_high,
    input  logic [2:0]  s_entry_index,
    input  logic [31:0] s_entry_low,
    input  logic [31:0] s_entry_high,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_match_kind,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import fdaf_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;

    logic   v1_reg, v1_next;
    logic   v2_reg, v2_next;
    logic   v3_reg, v3_next;
    item_t  item_reg, item_next;
    cmp_t   cmp_reg, cmp_next;
    kind_e  kind_reg, kind_next;

    logic   ready1, ready2, ready3;
    logic   tbl_wr;
    table_t entries;
    cmp_t   cmp;
    kind_e  kind;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_e'(cfg_index))
                CFG_PAN_ID:        cfg_next.pan_id        = cfg_data[15:0];
                CFG_OWN_ADDR_LOW:  cfg_next.own_addr_low  = cfg_data;
                CFG_OWN_ADDR_HIGH: cfg_next.own_addr_high = cfg_data;
                CFG_EXTRA_ENABLE:  cfg_next.extra_enable  = cfg_data[0];
                CFG_EXTRA_COUNT:   cfg_next.extra_count   = cfg_data[2:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // per-stage advance, a stage moves when it is empty or its successor moves
    assign ready3  = !v3_reg || m_ready;
    assign ready2  = !v2_reg || ready3;
    assign ready1  = !v1_reg || ready2;
    assign s_ready = ready1;

    // table write happens as the write word leaves stage one
    assign tbl_wr = v1_reg && ready2 && (item_reg.cmd == CMD_WRITE);

    fdaf_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (tbl_wr),
        .wr_index (item_reg.entry_index),
        .wr_data  ({item_reg.entry_high, item_reg.entry_low}),
        .entries  (entries)
    );

    fdaf_compare u_compare (
        .item    (item_reg),
        .cfg     (cfg_reg),
        .entries (entries),
        .cmp     (cmp)
    );

    fdaf_resolve u_resolve (
        .cmp          (cmp_reg),
        .extra_enable (cfg_reg.extra_enable),
        .kind         (kind)
    );

    // stage next values
    always_comb begin
        v1_next   = v1_reg;
        v2_next   = v2_reg;
        v3_next   = v3_reg;
        item_next = item_reg;
        cmp_next  = cmp_reg;
        kind_next = kind_reg;

        if (ready1) begin
            v1_next = s_valid;
            item_next.cmd         = cmd_e'(s_cmd);
            item_next.dest_pan    = s_dest_pan;
            item_next.dest_mode   = s_dest_mode;
            item_next.dest_low    = s_dest_low;
            item_next.dest_high   = s_dest_high;
            item_next.entry_index = s_entry_index;
            item_next.entry_low   = s_entry_low;
            item_next.entry_high  = s_entry_high;
        end

        // write words drop out after stage one
        if (ready2) begin
            v2_next  = v1_reg && (item_reg.cmd == CMD_FILTER);
            cmp_next = cmp;
        end

        if (ready3) begin
            v3_next   = v2_reg;
            kind_next = kind;
        end
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        cmp_reg  <= cmp_next;
        kind_reg <= kind_next;
    end

    assign m_valid      = v3_reg;
    assign m_match_kind = kind_reg;

endmodule

>>> sv/fdaf_table.sv
// ----------------------------------------------------------------------------
// fdaf_table
// Secondary address table. One 64-bit register per slot, cleared at reset,
// loaded by write words; every slot is presented to its own compare lane.
// ----------------------------------------------------------------------------
module fdaf_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [fdaf_pkg::IDX_W-1:0]        wr_index,
    input  logic [fdaf_pkg::ENTRY_W-1:0]      wr_data,
    output fdaf_pkg::table_t                  entries
);
    import fdaf_pkg::*;

    table_t entries_reg;
    table_t entries_next;

    // slot write, out-of-range index leaves the table alone
    always_comb begin
        entries_next = entries_reg;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (wr_en && (int'(wr_index) == i)) begin
                entries_next[i] = wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= '0;
        end else begin
            entries_reg <= entries_next;
        end
    end

    assign entries = entries_reg;

endmodule

>>> sv/fdaf_compare.sv
// ----------------------------------------------------------------------------
// fdaf_compare
// Address compare stage: PAN check, broadcast detection, own address and
// one compare lane per table slot, each lane masked by the entry count.
// ----------------------------------------------------------------------------
module fdaf_compare (
    input  fdaf_pkg::item_t  item,
    input  fdaf_pkg::cfg_t   cfg,
    input  fdaf_pkg::table_t entries,
    output fdaf_pkg::cmp_t   cmp
);
    import fdaf_pkg::*;

    logic                   is_short;
    logic                   is_ext;
    logic [SHORT_W-1:0]     short_addr;
    logic                   short_bcast;
    logic                   ext_bcast;
    logic [TABLE_DEPTH-1:0] lane_hit;

    assign is_short   = (item.dest_mode == MODE_SHORT);
    assign is_ext     = (item.dest_mode == MODE_EXTENDED);
    assign short_addr = item.dest_low[SHORT_W-1:0];

    // broadcast patterns
    assign short_bcast = (short_addr == SHORT_BCAST) || (short_addr == SHORT_BCAST_ALT);
    assign ext_bcast   = ((item.dest_low == EXT_BCAST_LO) || (item.dest_low == EXT_BCAST_LO_ALT))
                         && (item.dest_high == EXT_BCAST_HI);

    // table lanes, only slots below the entry count take part
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (is_short) begin
                lane_hit[i] = (entries[i][SHORT_W-1:0] == short_addr);
            end else begin
                lane_hit[i] = (entries[i] == {item.dest_high, item.dest_low});
            end
            lane_hit[i] = lane_hit[i] && (int'(cfg.extra_count) > i);
        end
    end

    always_comb begin
        cmp.pan_ok    = (item.dest_pan == cfg.pan_id);
        cmp.addr_mode = is_short || is_ext;
        cmp.bcast     = is_short ? short_bcast : ext_bcast;
        cmp.own_hit   = is_short
                        ? (cfg.own_addr_low[SHORT_W-1:0] == short_addr)
                        : ((cfg.own_addr_low == item.dest_low)
                           && (cfg.own_addr_high == item.dest_high));
        cmp.lane_hit  = lane_hit;
    end

endmodule

>>> sv/fdaf_resolve.sv
// ----------------------------------------------------------------------------
// fdaf_resolve
// Resolve stage: folds the registered compare flags into the match kind,
// broadcast first, then own address, then the enabled table lanes.
// ----------------------------------------------------------------------------
module fdaf_resolve (
    input  fdaf_pkg::cmp_t cmp,
    input  logic           extra_enable,
    output fdaf_pkg::kind_e kind
);
    import fdaf_pkg::*;

    logic table_hit;

    assign table_hit = extra_enable && (|cmp.lane_hit);

    // priority decode
    always_comb begin
        if (!cmp.pan_ok || !cmp.addr_mode) begin
            kind = KIND_NONE;
        end else if (cmp.bcast) begin
            kind = KIND_BROADCAST;
        end else if (cmp.own_hit || table_hit) begin
            kind = KIND_UNICAST;
        end else begin
            kind = KIND_NONE;
        end
    end

endmodule

>>> sv/fdaf_checker.sv
// ----------------------------------------------------------------------------
// fdaf_checker
// Port-level checks for the address filter: result hold under stall,
// back-pressure only with a stalled output, filter result latency, reset.
// ----------------------------------------------------------------------------
module fdaf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_cmd,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_match_kind
);
    import fdaf_pkg::*;

    logic filter_acc;

    assign filter_acc = s_valid && s_ready && (s_cmd == CMD_FILTER);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_match_kind))
        else $error("result word changed while stalled");

    // input back-pressure only with a stalled result at the output
    a_bp_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // filter word reaches the output through the input, compare and resolve registers while m_ready stays high
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        filter_acc ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("filter result missing after pipeline latency");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind frame_dest_address_filter_top fdaf_checker u_fdaf_checker (.*);
